[rtl/ordered_grid_list_engine_unit_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ORDERED_GRID_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_GRID_LIST_ENGINE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OGLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OGLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ogle_pkg.sv]
package ogle_pkg;

  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_COORD_BITS = 8;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_MIN     = 3'd3,
    OP_LENGTH  = 3'd4,
    OP_REVERSE = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL,
    CELL_SWP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctl_t;

endpackage

[rtl/ogle_cell.sv]
module ogle_cell #(
  parameter int unsigned CAPACITY   = ogle_pkg::DEF_CAPACITY,
  parameter int unsigned COORD_BITS = ogle_pkg::DEF_COORD_BITS,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                           clk_i,
  input  ogle_pkg::cell_ctl_t            ctl_i,
  input  logic [$clog2(CAPACITY)-1:0]    at_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  cnt_i,
  input  logic [2*COORD_BITS+31:0]       new_i,
  input  logic [2*COORD_BITS+31:0]       left_i,
  input  logic [2*COORD_BITS+31:0]       right_i,
  output logic [2*COORD_BITS+31:0]       data_o
);
  import ogle_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = 2 * COORD_BITS + 32;

  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] NEXT_CNT = CNT_W'(CELL_IDX + 1);
  localparam logic             PARITY   = 1'(CELL_IDX % 2);
  localparam bit               HAS_LEFT = (CELL_IDX > 0);

  logic [ENT_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_ROT: begin
        data_d = right_i;
      end
      CELL_INS: begin
        if (at_i == MY_IDX) begin
          data_d = new_i;
        end else if (MY_IDX > at_i) begin
          data_d = left_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= at_i) begin
          data_d = right_i;
        end
      end
      CELL_SWP: begin
        // pair (i, i+1) swaps when i matches the round parity and both are live
        if (PARITY == ctl_i.phase && NEXT_CNT < cnt_i) begin
          data_d = right_i;
        end else if (PARITY != ctl_i.phase && HAS_LEFT && MY_CNT < cnt_i) begin
          data_d = left_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/ogle_ctrl.sv]
module ogle_ctrl #(
  parameter int unsigned CAPACITY   = ogle_pkg::DEF_CAPACITY,
  parameter int unsigned COORD_BITS = ogle_pkg::DEF_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [ogle_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic [ogle_pkg::OP_W-1:0]           s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [ogle_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output ogle_pkg::cell_ctl_t                 ctl_o,
  output logic [$clog2(CAPACITY)-1:0]         at_o,
  output logic [$clog2(CAPACITY+1)-1:0]       cnt_o,
  output logic [2*COORD_BITS+31:0]            new_o,
  input  logic [2*COORD_BITS+31:0]            head_i
);
  import ogle_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = 2 * COORD_BITS + 32;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned MW    = (COORD_BITS < 8) ? COORD_BITS : 8;
  localparam int unsigned CW    = COORD_BITS;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CAPACITY - 1);
  localparam logic [CMP_W-1:0] CAP_CMP   = CMP_W'(CAPACITY);

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [ENT_W-1:0]     new_q, new_d;
  logic [CNT_W-1:0]     step_q, step_d;
  logic                 hit_q, hit_d;
  logic [CNT_W-1:0]     hpos_q, hpos_d;
  logic [ENT_W-1:0]     hdat_q, hdat_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 mval_q, mval_d;
  logic [OUT_DATA_W-1:0] mdat_q, mdat_d;

  cell_ctl_t            ctl;
  logic                 res_ok;
  logic [POS_W-1:0]     res_pos;
  logic [ENT_W-1:0]     res_dat;
  logic [CMP_W-1:0]     pos_cmp, cnt_cmp, step_cmp;
  logic                 ins_ok, del_ok, live, better;
  logic [15:0]          head_f, head_g, best_f, best_g;

  assign pos_cmp  = CMP_W'(pos_q);
  assign cnt_cmp  = CMP_W'(cnt_q);
  assign step_cmp = CMP_W'(step_q);
  assign ins_ok   = (pos_q != '0) && (pos_cmp <= cnt_cmp + CMP_W'(1)) && (cnt_cmp < CAP_CMP);
  assign del_ok   = (pos_q != '0) && (pos_cmp <= cnt_cmp);
  assign live     = step_q < cnt_q;

  assign head_f = head_i[2*CW+15:2*CW];
  assign head_g = head_i[2*CW+31:2*CW+16];
  assign best_f = hdat_q[2*CW+15:2*CW];
  assign best_g = hdat_q[2*CW+31:2*CW+16];
  assign better = !hit_q || (head_f < best_f) || ((head_f == best_f) && (head_g < best_g));

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    new_d     = new_q;
    step_d    = step_q;
    hit_d     = hit_q;
    hpos_d    = hpos_q;
    hdat_d    = hdat_q;
    cnt_d     = cnt_q;
    mval_d    = mval_q;
    mdat_d    = mdat_q;
    ctl.op    = CELL_HOLD;
    ctl.phase = 1'b0;
    s_tready_o = 1'b0;
    res_ok    = 1'b0;
    res_pos   = '0;
    res_dat   = '0;

    if (mval_q && m_tready_i) begin
      mval_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          op_d   = op_e'(s_tuser_i);
          pos_d  = s_tdata_i[6:0];
          new_d  = {s_tdata_i[54:39], s_tdata_i[38:23],
                    CW'(s_tdata_i[15+MW-1:15]), CW'(s_tdata_i[7+MW-1:7])};
          step_d = '0;
          hit_d  = 1'b0;
          hpos_d = '0;
          hdat_d = '0;
          unique case (op_e'(s_tuser_i)) inside
            OP_SEARCH, OP_MIN, OP_DELETE: state_d = ST_SCAN;
            OP_REVERSE:                   state_d = ST_SWAP;
            default:                      state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        ctl.op = CELL_ROT;
        if (live) begin
          case (op_q)
            OP_SEARCH: begin
              if (!hit_q && head_i[CW-1:0] == new_q[CW-1:0] &&
                  head_i[2*CW-1:CW] == new_q[2*CW-1:CW]) begin
                hit_d  = 1'b1;
                hpos_d = step_q + CNT_W'(1);
              end
            end
            OP_MIN: begin
              if (better) begin
                hit_d  = 1'b1;
                hpos_d = step_q + CNT_W'(1);
                hdat_d = head_i;
              end
            end
            OP_DELETE: begin
              if (step_cmp + CMP_W'(1) == pos_cmp) begin
                hdat_d = head_i;
              end
            end
            default: begin
            end
          endcase
        end
        step_d = step_q + CNT_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_SWAP: begin
        if (step_q == cnt_q) begin
          state_d = ST_FIN;
        end else begin
          ctl.op    = CELL_SWP;
          ctl.phase = step_q[0];
          step_d    = step_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!mval_q || m_tready_i) begin
          case (op_q)
            OP_INSERT: begin
              if (ins_ok) begin
                res_ok = 1'b1;
                ctl.op = CELL_INS;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (del_ok) begin
                res_ok  = 1'b1;
                res_pos = pos_q;
                res_dat = hdat_q;
                ctl.op  = CELL_DEL;
                cnt_d   = cnt_q - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              res_ok  = hit_q;
              res_pos = POS_W'(hpos_q);
            end
            OP_MIN: begin
              res_ok  = hit_q;
              res_pos = POS_W'(hpos_q);
              res_dat = hdat_q;
            end
            OP_LENGTH: begin
              res_ok = 1'b1;
            end
            OP_REVERSE: begin
              res_ok = 1'b1;
            end
            OP_CLEAR: begin
              res_ok = 1'b1;
              cnt_d  = '0;
            end
            default: begin
            end
          endcase
          mval_d  = 1'b1;
          mdat_d  = {1'b0, POS_W'(cnt_d),
                     res_dat[2*CW+31:2*CW+16], res_dat[2*CW+15:2*CW],
                     8'(res_dat[CW+MW-1:CW]), 8'(res_dat[MW-1:0]),
                     res_pos, res_ok};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mval_q  <= 1'b0;
      step_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mval_q  <= mval_d;
      step_q  <= step_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    new_q  <= new_d;
    hpos_q <= hpos_d;
    hdat_q <= hdat_d;
    mdat_q <= mdat_d;
  end

  assign ctl_o      = ctl;
  assign at_o       = IDX_W'(pos_cmp - CMP_W'(1));
  assign cnt_o      = cnt_q;
  assign new_o      = new_q;
  assign m_tvalid_o = mval_q;
  assign m_tdata_o  = mdat_q;

endmodule

[rtl/ordered_grid_list_engine_unit.sv]
// Insert, length, clear and unknown opcodes go from the input transfer straight to the finish state.
// Search, min select and delete first scan one full rotation of the cell chain.
// Reverse runs one odd/even swap round per stored entry, then one closing step before finishing.
// One item in flight at a time; the next transfer is taken once the result is registered.
// Reset (rst_ni low, async) empties the list and drops any pending result;
// cell contents are not cleared and are never read beyond the entry count.
module ordered_grid_list_engine_unit #(
  parameter int unsigned CAPACITY   = ogle_pkg::DEF_CAPACITY,
  parameter int unsigned COORD_BITS = ogle_pkg::DEF_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position[6:0], x_coord[14:7], y_coord[22:15], f_cost[38:23], g_cost[54:39], zero[55]
  input  logic [ogle_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode[2:0]
  input  logic [ogle_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // ok[0], found_position[7:1], out_x[15:8], out_y[23:16], out_f[39:24], out_g[55:40],
  // length[62:56], zero[63]
  output logic [ogle_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import ogle_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = 2 * COORD_BITS + 32;

  // Broadcast control from the sequencer to every cell of the chain.
  cell_ctl_t        ctl;
  logic [IDX_W-1:0] at;
  logic [CNT_W-1:0] cnt;
  logic [ENT_W-1:0] new_ent;

  // Entry held by each cell; cell 0 is the list head and feeds the scan logic.
  logic [ENT_W-1:0] cell_data [CAPACITY];

  ogle_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .ctl_o      (ctl),
    .at_o       (at),
    .cnt_o      (cnt),
    .new_o      (new_ent),
    .head_i     (cell_data[0])
  );

  // Ring of cells: rotate shifts toward the head, insert shifts away from it,
  // swap rounds exchange neighboring pairs to reverse the live prefix.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned LEFT  = (i + CAPACITY - 1) % CAPACITY;
    localparam int unsigned RIGHT = (i + 1) % CAPACITY;

    ogle_cell #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .at_i    (at),
      .cnt_i   (cnt),
      .new_i   (new_ent),
      .left_i  (cell_data[LEFT]),
      .right_i (cell_data[RIGHT]),
      .data_o  (cell_data[i])
    );
  end

endmodule

[rtl/ogle_checker.sv]
`include "ordered_grid_list_engine_unit_macros.svh"

module ogle_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [ogle_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input logic [ogle_pkg::OP_W-1:0]         s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ogle_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import ogle_pkg::*;

  logic in_xfer;
  logic out_stall;
  logic [OP_W+IN_DATA_W-1:0] in_word;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_word   = {s_axis_tuser, s_axis_tdata};

  // one item at a time: busy right after a transfer is taken
  `OGLE_ASSERT_NEXT(a_busy_after_xfer, in_xfer && (in_word == in_word), !s_axis_tready, "ready held after input transfer")

  // held result keeps its contents until taken
  `OGLE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a failed operation reports no position and no cell data
  `OGLE_ASSERT_NOW(a_fail_clean, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[55:1] == '0, "failed result carries data")

endmodule

bind ordered_grid_list_engine_unit ogle_checker u_ogle_checker (.*);

[dv/ogle_list_checker.sv]
`timescale 1ns / 1ps
module ogle_list_checker #(
  parameter int unsigned CAPACITY = ogle_pkg::DEF_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [ogle_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic [ogle_pkg::OP_W-1:0]         in_op_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [ogle_pkg::OUT_DATA_W-1:0]   out_data_i,
  output int unsigned                       err_count_o,
  output int unsigned                       pending_o
);

  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] f;
    logic [15:0] g;
  } grid_cell_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  pos;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] f;
    logic [15:0] g;
    logic [6:0]  len;
  } list_reply_t;

  grid_cell_t  open_cells [CAPACITY];
  int          open_len;
  list_reply_t pending_replies [$];
  int unsigned err_total;

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    err_total++;
    if (err_total <= MAX_PRINTS) begin
      $display("%0t ogle_list_checker: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  // Apply one operation to the shadow open list and return the reply it must give.
  function automatic list_reply_t apply_list_op(logic [ogle_pkg::OP_W-1:0] op,
                                                logic [6:0] pos_in, grid_cell_t item);
    list_reply_t res;
    grid_cell_t  tmp;
    int          pos;
    int          i;
    int          best;
    int          lo;
    int          hi;
    res = '0;
    pos = int'(pos_in);
    case (op)
      ogle_pkg::OP_INSERT: begin
        if (pos >= 1 && pos <= open_len + 1 && open_len < int'(CAPACITY)) begin
          for (i = open_len; i >= pos; i--) open_cells[i] = open_cells[i-1];
          open_cells[pos-1] = item;
          open_len++;
          res.ok = 1'b1;
        end
      end
      ogle_pkg::OP_DELETE: begin
        if (pos >= 1 && pos <= open_len) begin
          tmp = open_cells[pos-1];
          {res.x, res.y, res.f, res.g} = tmp;
          for (i = pos - 1; i < open_len - 1; i++) open_cells[i] = open_cells[i+1];
          open_len--;
          res.ok  = 1'b1;
          res.pos = pos_in;
        end
      end
      ogle_pkg::OP_SEARCH: begin
        for (i = 0; i < open_len; i++) begin
          if (!res.ok && open_cells[i].x == item.x && open_cells[i].y == item.y) begin
            res.ok  = 1'b1;
            res.pos = 7'(i + 1);
          end
        end
      end
      ogle_pkg::OP_MIN: begin
        if (open_len > 0) begin
          best = 0;
          for (i = 1; i < open_len; i++) begin
            if (open_cells[i].f < open_cells[best].f ||
                (open_cells[i].f == open_cells[best].f &&
                 open_cells[i].g < open_cells[best].g)) begin
              best = i;
            end
          end
          {res.x, res.y, res.f, res.g} = open_cells[best];
          res.ok  = 1'b1;
          res.pos = 7'(best + 1);
        end
      end
      ogle_pkg::OP_LENGTH: begin
        res.ok = 1'b1;
      end
      ogle_pkg::OP_REVERSE: begin
        lo = 0;
        hi = open_len - 1;
        while (lo < hi) begin
          tmp            = open_cells[lo];
          open_cells[lo] = open_cells[hi];
          open_cells[hi] = tmp;
          lo++;
          hi--;
        end
        res.ok = 1'b1;
      end
      ogle_pkg::OP_CLEAR: begin
        open_len = 0;
        res.ok   = 1'b1;
      end
      default: begin
      end
    endcase
    res.len = 7'(open_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    list_reply_t got;
    list_reply_t want;
    grid_cell_t  item;
    if (!rst_ni) begin
      pending_replies.delete();
      open_len    = 0;
      err_total   = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // Retire results first: a result and the next input may transfer on the same edge.
      if (out_valid_i && out_ready_i) begin
        got.ok  = out_data_i[0];
        got.pos = out_data_i[7:1];
        got.x   = out_data_i[15:8];
        got.y   = out_data_i[23:16];
        got.f   = out_data_i[39:24];
        got.g   = out_data_i[55:40];
        got.len = out_data_i[62:56];
        if (pending_replies.size() == 0) begin
          report_mismatch("result with nothing pending", 0, out_data_i);
        end else begin
          want = pending_replies.pop_front();
          if (got.ok  != want.ok)  report_mismatch("ok", want.ok, got.ok);
          if (got.pos != want.pos) report_mismatch("found_position", want.pos, got.pos);
          if (got.x   != want.x)   report_mismatch("out_x", want.x, got.x);
          if (got.y   != want.y)   report_mismatch("out_y", want.y, got.y);
          if (got.f   != want.f)   report_mismatch("out_f", want.f, got.f);
          if (got.g   != want.g)   report_mismatch("out_g", want.g, got.g);
          if (got.len != want.len) report_mismatch("length", want.len, got.len);
        end
      end
      if (in_valid_i && in_ready_i) begin
        item.x = in_data_i[14:7];
        item.y = in_data_i[22:15];
        item.f = in_data_i[38:23];
        item.g = in_data_i[54:39];
        pending_replies.push_back(apply_list_op(in_op_i, in_data_i[6:0], item));
      end
      err_count_o <= err_total;
      pending_o   <= pending_replies.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CAPACITY     = ogle_pkg::DEF_CAPACITY;
  localparam int          RESET_CYCLES = 11;
  localparam int          RANDOM_ITEMS = 1350;
  localparam int          HOLD_CYCLES  = 400;
  // Longest item is about a full rotation of the cell chain; leave margin on top.
  localparam int          DRAIN_CYCLES = CAPACITY + 16;
  // Opcode seven has no function and must be rejected.
  localparam logic [ogle_pkg::OP_W-1:0] OP_SPARE = 3'd7;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} mix_mode_e;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ogle_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [ogle_pkg::OP_W-1:0]         s_axis_tuser  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ogle_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

  int unsigned err_count;
  int unsigned pending;
  int          traffic_phase = 0;   // 0: sender lightly idle, 1: receiver lightly idle, 2: none
  int          list_count    = 0;   // rough fill level, only used to aim positions

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ordered_grid_list_engine_unit #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (ogle_pkg::DEF_COORD_BITS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  ogle_list_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic int tx_idle_pct();
    case (traffic_phase)
      0:       return 29;
      1:       return 68;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (traffic_phase)
      0:       return 68;
      1:       return 29;
      default: return 0;
    endcase
  endfunction

  // Offer one item, holding it until the transfer; track the fill level on the side.
  task automatic send_item(logic [ogle_pkg::OP_W-1:0] op, logic [6:0] pos,
                           logic [7:0] x, logic [7:0] y, logic [15:0] f, logic [15:0] g);
    while ($urandom_range(99) < tx_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, g, f, y, x, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      ogle_pkg::OP_INSERT:
        if (pos >= 1 && pos <= list_count + 1 && list_count < int'(CAPACITY)) list_count++;
      ogle_pkg::OP_DELETE:
        if (pos >= 1 && pos <= list_count) list_count--;
      ogle_pkg::OP_CLEAR:
        list_count = 0;
      default: begin
      end
    endcase
  endtask

  // Pick an opcode; the mode biases the list toward growing, churning or shrinking.
  function automatic logic [ogle_pkg::OP_W-1:0] pick_op(mix_mode_e mode);
    int r;
    int s;
    int w_ins;
    int w_del;
    int w_clr;
    case (mode)
      MODE_FILL: begin
        w_ins = 60; w_del = 10; w_clr = 0;
      end
      MODE_DRAIN: begin
        w_ins = 15; w_del = 50; w_clr = 1;
      end
      default: begin
        w_ins = 35; w_del = 25; w_clr = 2;
      end
    endcase
    r = $urandom_range(99);
    if (r < w_ins) return ogle_pkg::OP_INSERT;
    if (r < w_ins + w_del) return ogle_pkg::OP_DELETE;
    if (r < w_ins + w_del + w_clr) return ogle_pkg::OP_CLEAR;
    s = $urandom_range(19);
    if (s < 6)  return ogle_pkg::OP_SEARCH;
    if (s < 12) return ogle_pkg::OP_MIN;
    if (s < 14) return ogle_pkg::OP_LENGTH;
    if (s < 19) return ogle_pkg::OP_REVERSE;
    return OP_SPARE;
  endfunction

  // Small coordinate pool so searches hit and duplicates appear; full range otherwise.
  function automatic logic [7:0] pick_coord();
    if ($urandom_range(99) < 70) return 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // Small costs give F and G ties for the minimum select.
  function automatic logic [15:0] pick_cost();
    if ($urandom_range(99) < 50) return 16'($urandom_range(7));
    return 16'($urandom_range(65535));
  endfunction

  // Receiver: random backpressure, plus one long hold-off once idling stops so the
  // block fills up and has to stall its input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (traffic_phase == 2 && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  initial begin : stimulus
    int          n;
    mix_mode_e   mode;
    logic [2:0]  op;
    logic [6:0]  pos;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every query and removal must fail or report zero.
    send_item(ogle_pkg::OP_LENGTH,  7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_MIN,     7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_SEARCH,  7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_DELETE,  7'd1, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_REVERSE, 7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    // Insert positions out of range: zero, one past the end; then a valid insert of the widest values.
    send_item(ogle_pkg::OP_INSERT,  7'd0, 8'd1, 8'd1, 16'd1, 16'd1);
    send_item(ogle_pkg::OP_INSERT,  7'd2, 8'd1, 8'd1, 16'd1, 16'd1);
    send_item(ogle_pkg::OP_INSERT,  7'd1, 8'hff, 8'hff, 16'hffff, 16'hffff);
    send_item(ogle_pkg::OP_REVERSE, 7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_INSERT,  7'd2, 8'd0, 8'd0, 16'd0, 16'd0);
    // Same F as a cell already in the list but larger G: the tie must go to G.
    send_item(ogle_pkg::OP_INSERT,  7'd1, 8'haa, 8'h55, 16'd0, 16'd5);
    send_item(ogle_pkg::OP_INSERT,  7'd127, 8'd3, 8'd3, 16'd3, 16'd3);
    send_item(ogle_pkg::OP_SEARCH,  7'd0, 8'hff, 8'hff, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_SEARCH,  7'd0, 8'd1, 8'd2, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_MIN,     7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_REVERSE, 7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_MIN,     7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_SEARCH,  7'd0, 8'hff, 8'hff, 16'd0, 16'd0);
    // Delete positions out of range, then a valid one at the tail.
    send_item(ogle_pkg::OP_DELETE,  7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_DELETE,  7'd4, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_DELETE,  7'd3, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(OP_SPARE,             7'd1, 8'd1, 8'd1, 16'd1, 16'd1);
    send_item(ogle_pkg::OP_CLEAR,   7'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(ogle_pkg::OP_LENGTH,  7'd0, 8'd0, 8'd0, 16'd0, 16'd0);

    // Random part: cycle fill, churn and drain so the list reaches full and empty often.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      traffic_phase = (n * 3) / RANDOM_ITEMS;
      mode = mix_mode_e'((n / 150) % 3);
      op   = pick_op(mode);
      if (op == ogle_pkg::OP_INSERT && $urandom_range(99) < 85) begin
        pos = 7'($urandom_range(list_count + 1, 1));
      end else if (op == ogle_pkg::OP_DELETE && list_count > 0 && $urandom_range(99) < 85) begin
        pos = 7'($urandom_range(list_count, 1));
      end else begin
        pos = 7'($urandom_range(127));
      end
      send_item(op, pos, pick_coord(), pick_coord(), pick_cost(), pick_cost());
    end
    s_axis_tvalid <= 1'b0;

    // Let the last transfer reach the checker, drain, then watch for stray results.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a timeout several times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
